// File: sv/float_color_pixel_packer_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pixel packer
// Clocked assertion helpers used by the top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef FLOAT_COLOR_PIXEL_PACKER_MACROS_SVH
`define FLOAT_COLOR_PIXEL_PACKER_MACROS_SVH

`define FCPP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");

`define FCPP_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("reset assertion failed");

`endif

// File: sv/fcpp_pkg.sv
// ----------------------------------------------------------------------------
// Pixel packer package
// Format codes, scale selection, small-float constants and stage enables.
// ----------------------------------------------------------------------------
package fcpp_pkg;

  localparam logic [1:0] ACT_RGBA8      = 2'd0;
  localparam logic [1:0] ACT_RGB10A2    = 2'd1;
  localparam logic [1:0] ACT_R11G11B10F = 2'd2;
  localparam logic [1:0] ACT_UNUSED     = 2'd3;

  typedef enum logic [1:0] {
    SC_255  = 2'd0,
    SC_1023 = 2'd1,
    SC_3    = 2'd2
  } scale_t;

  typedef struct packed {
    logic en_a;
    logic en_b;
  } stage_en_t;

  localparam logic [30:0] SF_CLAMP  = 31'h47800000;
  localparam logic [30:0] SF_REBIAS = 31'h38000000;
  localparam logic [27:0] RG_R1   = 28'h0010000;
  localparam logic [27:0] RG_R2   = 28'h000FFFF;
  localparam logic [27:0] RG_MASK = 28'hFFE0000;
  localparam logic [27:0] B_R1    = 28'h0020000;
  localparam logic [27:0] B_R2    = 28'h001FFFF;
  localparam logic [27:0] B_MASK  = 28'hFFC0000;

  function automatic logic [9:0] scale_value(scale_t sc);
    logic [9:0] v;
    case (sc)
      SC_255:  v = 10'd255;
      SC_1023: v = 10'd1023;
      SC_3:    v = 10'd3;
      default: v = 10'd255;
    endcase
    return v;
  endfunction

  function automatic logic [3:0] scale_width(scale_t sc);
    logic [3:0] w;
    case (sc)
      SC_255:  w = 4'd8;
      SC_1023: w = 4'd10;
      SC_3:    w = 4'd2;
      default: w = 4'd8;
    endcase
    return w;
  endfunction

endpackage

// File: sv/fcpp_unorm_lane.sv
// ----------------------------------------------------------------------------
// Unsigned normalised lane
// Saturates one float32 channel, scales it with float32 rounding and
// rounds the result half to even to an integer code.
// ----------------------------------------------------------------------------
module fcpp_unorm_lane (
  input  logic               clk,
  input  fcpp_pkg::stage_en_t en,
  input  logic [31:0]        bits_in,
  input  fcpp_pkg::scale_t   scale_in,
  output logic [9:0]         code
);

  logic [33:0] p_r, p_nxt;
  logic [7:0]  e_r, e_nxt;
  logic        zero_a_r, zero_a_nxt;
  fcpp_pkg::scale_t sc_r;
  logic [24:0] pq_r, pq_nxt;
  logic [7:0]  sh_r, sh_nxt;
  logic        zero_b_r;

  logic [7:0]  ex;
  logic        one_f;
  logic [23:0] mant;
  logic [3:0]  w, k;
  logic [33:0] q, rem_b, half_b;
  logic        up_b;
  logic [4:0]  sh5;
  logic [24:0] n, rem_c, half_c;
  logic        up_c;

  always_comb begin
    ex = bits_in[30:23];
    zero_a_nxt = bits_in[31] || (ex == 8'd0) || ((ex == 8'hFF) && (bits_in[22:0] != 23'd0));
    one_f = (ex >= 8'd127);
    mant = one_f ? 24'h800000 : {1'b1, bits_in[22:0]};
    e_nxt = one_f ? 8'd127 : ex;
    p_nxt = {10'd0, mant} * {24'd0, fcpp_pkg::scale_value(scale_in)};
  end

  always_ff @(posedge clk) begin
    if (en.en_a) begin
      p_r <= p_nxt;
      e_r <= e_nxt;
      zero_a_r <= zero_a_nxt;
      sc_r <= scale_in;
    end
  end

  always_comb begin
    w = fcpp_pkg::scale_width(sc_r);
    k = p_r[6'd23 + {2'd0, w}] ? w : w - 4'd1;
    q = p_r >> k;
    rem_b = p_r & ((34'd1 << k) - 34'd1);
    half_b = 34'd1 << (k - 4'd1);
    up_b = (rem_b > half_b) || ((rem_b == half_b) && q[0]);
    pq_nxt = q[24:0] + {24'd0, up_b};
    sh_nxt = 8'd150 - e_r - {4'd0, k};
  end

  always_ff @(posedge clk) begin
    if (en.en_b) begin
      pq_r <= pq_nxt;
      sh_r <= sh_nxt;
      zero_b_r <= zero_a_r;
    end
  end

  always_comb begin
    sh5 = sh_r[4:0];
    n = pq_r >> sh5;
    rem_c = pq_r & ((25'd1 << sh5) - 25'd1);
    half_c = 25'd1 << (sh5 - 5'd1);
    up_c = (rem_c > half_c) || ((rem_c == half_c) && n[0]);
    if (zero_b_r || (sh_r >= 8'd26)) begin
      code = 10'd0;
    end else begin
      code = n[9:0] + {9'd0, up_c};
    end
  end

endmodule

// File: sv/fcpp_sf_lane.sv
// ----------------------------------------------------------------------------
// Small-float lane
// Clamps one float32 channel, rebiases it into the small-float range and
// applies the selected rounding before masking the kept bits.
// ----------------------------------------------------------------------------
module fcpp_sf_lane (
  input  logic               clk,
  input  fcpp_pkg::stage_en_t en,
  input  logic [31:0]        bits_in,
  input  logic               even_in,
  input  logic               is_blue,
  output logic [27:0]        code
);

  logic [30:0] val_r, val_nxt;
  logic [4:0]  s_r, s_nxt;
  logic        big_r, big_nxt, zero_r, zero_nxt, even_a_r;
  logic [27:0] t_r, t_nxt;
  logic        even_b_r;

  logic [30:0] c;
  logic [7:0]  ex, s8;
  logic [23:0] m, q, rem, half;
  logic        up;
  logic [27:0] r1, r2, msk, odd, add;
  logic [28:0] sum;

  always_comb begin
    c = (bits_in[30:0] > fcpp_pkg::SF_CLAMP) ? fcpp_pkg::SF_CLAMP : bits_in[30:0];
    ex = c[30:23];
    s8 = 8'd113 - ex;
    big_nxt = !bits_in[31] && (ex > 8'd112);
    zero_nxt = bits_in[31] || (ex == 8'd0) || (!big_nxt && (s8 >= 8'd25));
    s_nxt = s8[4:0];
    val_nxt = big_nxt ? (c - fcpp_pkg::SF_REBIAS) : {7'd0, 1'b1, c[22:0]};
  end

  always_ff @(posedge clk) begin
    if (en.en_a) begin
      val_r <= val_nxt;
      s_r <= s_nxt;
      big_r <= big_nxt;
      zero_r <= zero_nxt;
      even_a_r <= even_in;
    end
  end

  always_comb begin
    m = val_r[23:0];
    q = m >> s_r;
    rem = m & ((24'd1 << s_r) - 24'd1);
    half = 24'd1 << (s_r - 5'd1);
    up = (rem > half) || ((rem == half) && q[0]);
    if (big_r) begin
      t_nxt = val_r[27:0];
    end else if (zero_r) begin
      t_nxt = 28'd0;
    end else begin
      t_nxt = {4'd0, q + {23'd0, up}};
    end
  end

  always_ff @(posedge clk) begin
    if (en.en_b) begin
      t_r <= t_nxt;
      even_b_r <= even_a_r;
    end
  end

  always_comb begin
    r1 = is_blue ? fcpp_pkg::B_R1 : fcpp_pkg::RG_R1;
    r2 = is_blue ? fcpp_pkg::B_R2 : fcpp_pkg::RG_R2;
    msk = is_blue ? fcpp_pkg::B_MASK : fcpp_pkg::RG_MASK;
    odd = (t_r >> 1) & r1;
    add = even_b_r ? ((odd > r2) ? odd : r2) : r1;
    sum = {1'b0, t_r} + {1'b0, add};
    code = sum[27:0] & msk;
  end

endmodule

// File: sv/float_color_pixel_packer.sv
// Path: an accepted input moves through stage A (va_r), stage B (vb_r), then the output register.
// Throughput: one pixel per cycle while out_ready is high; the two lane register stages and the
// output register each advance whenever the stage after them is free.
// Reset: rst_n low clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// Float colour pixel packer
// Packs four float32 channels into RGBA8, RGB10A2 or R11G11B10F words.
// ----------------------------------------------------------------------------
`include "float_color_pixel_packer_macros.svh"

module float_color_pixel_packer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_red_bits,
  input  logic [31:0] in_green_bits,
  input  logic [31:0] in_blue_bits,
  input  logic [31:0] in_alpha_bits,
  input  logic        in_round_even,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_packed_pixel
);

  logic va_r, vb_r, vo_r;
  logic rdy_a, rdy_b, rdy_c;
  logic [1:0] act_a_r, act_b_r;
  logic [31:0] pix_r, pix_nxt;
  fcpp_pkg::stage_en_t en;
  fcpp_pkg::scale_t sc_col, sc_alpha;
  logic [9:0] ur, ug, ub, ua;
  logic [27:0] fr, fg, fb;

  assign rdy_c = !vo_r || out_ready;
  assign rdy_b = !vb_r || rdy_c;
  assign rdy_a = !va_r || rdy_b;
  assign in_ready = rdy_a;
  assign en.en_a = rdy_a;
  assign en.en_b = rdy_b;
  assign out_valid = vo_r;
  assign out_packed_pixel = pix_r;

  assign sc_col = (in_action == fcpp_pkg::ACT_RGB10A2) ? fcpp_pkg::SC_1023 : fcpp_pkg::SC_255;
  assign sc_alpha = (in_action == fcpp_pkg::ACT_RGB10A2) ? fcpp_pkg::SC_3 : fcpp_pkg::SC_255;

  fcpp_unorm_lane u_ur (.clk, .en, .bits_in(in_red_bits),   .scale_in(sc_col),   .code(ur));
  fcpp_unorm_lane u_ug (.clk, .en, .bits_in(in_green_bits), .scale_in(sc_col),   .code(ug));
  fcpp_unorm_lane u_ub (.clk, .en, .bits_in(in_blue_bits),  .scale_in(sc_col),   .code(ub));
  fcpp_unorm_lane u_ua (.clk, .en, .bits_in(in_alpha_bits), .scale_in(sc_alpha), .code(ua));

  fcpp_sf_lane u_fr (.clk, .en, .bits_in(in_red_bits),   .even_in(in_round_even),
                     .is_blue(1'b0), .code(fr));
  fcpp_sf_lane u_fg (.clk, .en, .bits_in(in_green_bits), .even_in(in_round_even),
                     .is_blue(1'b0), .code(fg));
  fcpp_sf_lane u_fb (.clk, .en, .bits_in(in_blue_bits),  .even_in(in_round_even),
                     .is_blue(1'b1), .code(fb));

  always_comb begin
    case (act_b_r)
      fcpp_pkg::ACT_RGBA8:      pix_nxt = {ua[7:0], ub[7:0], ug[7:0], ur[7:0]};
      fcpp_pkg::ACT_RGB10A2:    pix_nxt = {ua[1:0], ub, ug, ur};
      fcpp_pkg::ACT_R11G11B10F: pix_nxt = {fb[27:18], fg[27:17], fr[27:17]};
      default:                  pix_nxt = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (rdy_a) va_r <= in_valid;
      if (rdy_b) vb_r <= va_r;
      if (rdy_c) vo_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a) act_a_r <= in_action;
    if (rdy_b) act_b_r <= act_a_r;
    if (rdy_c) pix_r <= pix_nxt;
  end

  `FCPP_ASSERT(a_stall_keeps_b, (vb_r && vo_r && !out_ready) |=> vb_r)
  `FCPP_ASSERT(a_empty_a_ready, !va_r |-> in_ready)
  `FCPP_ASSERT(a_a_moves_to_b, (va_r && rdy_b) |=> vb_r)
  `FCPP_ASSERT_RST(a_reset_clears, !rst_n |=> (!vo_r && !vb_r && !va_r))

endmodule
